// ----- rtl/sqg_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register codes and types of the single-qubit gate update unit.
// No dependencies; every other file uses this package.
package sqg_pkg;

  localparam int ADDR_W         = 20;
  localparam int IDX_W          = 19;
  localparam int AMP_W          = 32;
  localparam int GATE_W         = 64;
  localparam int TGT_W          = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int FRAC_BITS      = 30;
  localparam int NUM_QUBITS_DEF = 20;

  localparam logic [GATE_W-1:0] GATE_ONE  = 64'h4000_0000_0000_0000;
  localparam logic [GATE_W-1:0] GATE_ZERO = 64'h0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 3'd0,
    CFG_UL     = 3'd1,
    CFG_UR     = 3'd2,
    CFG_LL     = 3'd3,
    CFG_LR     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [TGT_W-1:0]  target;
    logic [GATE_W-1:0] ul;
    logic [GATE_W-1:0] ur;
    logic [GATE_W-1:0] ll;
    logic [GATE_W-1:0] lr;
  } sqg_cfg_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] x0r;
    logic signed [AMP_W-1:0] x0i;
    logic signed [AMP_W-1:0] x1r;
    logic signed [AMP_W-1:0] x1i;
  } sqg_amp_t;

  // Load enables of the arithmetic stages.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } sqg_en_t;

endpackage

// ----- rtl/sqg_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for amplitude pairs in and updated pairs out.
// Depends on sqg_pkg for field widths.
interface sqg_in_if;
  logic                            valid;
  logic                            ready;
  logic [sqg_pkg::IDX_W-1:0]       pair_index;
  logic signed [sqg_pkg::AMP_W-1:0] zero_amp_re;
  logic signed [sqg_pkg::AMP_W-1:0] zero_amp_im;
  logic signed [sqg_pkg::AMP_W-1:0] one_amp_re;
  logic signed [sqg_pkg::AMP_W-1:0] one_amp_im;

  modport source(output valid, pair_index, zero_amp_re, zero_amp_im, one_amp_re, one_amp_im,
                 input ready);
  modport sink(input valid, pair_index, zero_amp_re, zero_amp_im, one_amp_re, one_amp_im,
               output ready);
endinterface

interface sqg_out_if;
  logic                             valid;
  logic                             ready;
  logic [sqg_pkg::ADDR_W-1:0]       zero_address;
  logic [sqg_pkg::ADDR_W-1:0]       one_address;
  logic signed [sqg_pkg::AMP_W-1:0] new_zero_re;
  logic signed [sqg_pkg::AMP_W-1:0] new_zero_im;
  logic signed [sqg_pkg::AMP_W-1:0] new_one_re;
  logic signed [sqg_pkg::AMP_W-1:0] new_one_im;

  modport source(output valid, zero_address, one_address, new_zero_re, new_zero_im,
                 new_one_re, new_one_im, input ready);
  modport sink(input valid, zero_address, one_address, new_zero_re, new_zero_im,
               new_one_re, new_one_im, output ready);
endinterface

// ----- rtl/sqg_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file: target qubit and the four gate matrix entries.
// Depends on sqg_pkg.
module sqg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sqg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sqg_pkg::GATE_W-1:0]    cfg_wdata,
  output sqg_pkg::sqg_cfg_t             cfg
);
  import sqg_pkg::*;

  sqg_cfg_t cfg_r;
  sqg_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET: cfg_nxt.target = cfg_wdata[TGT_W-1:0];
        CFG_UL:     cfg_nxt.ul     = cfg_wdata;
        CFG_UR:     cfg_nxt.ur     = cfg_wdata;
        CFG_LL:     cfg_nxt.ll     = cfg_wdata;
        CFG_LR:     cfg_nxt.lr     = cfg_wdata;
        default:    cfg_nxt        = cfg_r; // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= '0;
      cfg_r.ul     <= GATE_ONE;
      cfg_r.ur     <= GATE_ZERO;
      cfg_r.ll     <= GATE_ZERO;
      cfg_r.lr     <= GATE_ONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/sqg_addr_gen.sv -----
`timescale 1ns / 1ps
// Address generator: inserts a zero bit at the target position of the pair index.
// Depends on sqg_pkg.
module sqg_addr_gen #(
  parameter int NUM_QUBITS = sqg_pkg::NUM_QUBITS_DEF
) (
  input  logic [sqg_pkg::IDX_W-1:0]  pair_index,
  input  logic [sqg_pkg::TGT_W-1:0]  target,
  output logic [sqg_pkg::ADDR_W-1:0] zero_address,
  output logic [sqg_pkg::ADDR_W-1:0] one_address
);
  import sqg_pkg::*;

  localparam int AW = (NUM_QUBITS > ADDR_W) ? NUM_QUBITS : ADDR_W;
  localparam logic [AW-1:0] IDX_MASK = AW'((64'd1 << (NUM_QUBITS - 1)) - 64'd1);
  localparam logic [TGT_W:0] TGT_LIM = (TGT_W + 1)'(NUM_QUBITS);
  localparam logic [TGT_W:0] TGT_MAX = (TGT_W + 1)'(NUM_QUBITS - 1);

  logic [TGT_W:0] tq;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  bit_sel;
  logic [AW-1:0]  low_mask;
  logic [AW-1:0]  a0;

  always_comb begin
    // Clamp an out-of-range target to the top qubit.
    tq       = ({1'b0, target} >= TGT_LIM) ? TGT_MAX : {1'b0, target};
    idx      = AW'(pair_index) & IDX_MASK;
    bit_sel  = AW'(1) << tq;
    low_mask = bit_sel - AW'(1);
    a0       = (idx & low_mask) | ((idx & ~low_mask) << 1);
  end

  assign zero_address = a0[ADDR_W-1:0];
  assign one_address  = a0[ADDR_W-1:0] | bit_sel[ADDR_W-1:0];

endmodule

// ----- rtl/sqg_cmac.sv -----
`timescale 1ns / 1ps
// Complex multiply-add lane m0*x0 + m1*x1: products, pair sums, final sum with
// floor to Q2.30 and saturation, one register stage each. Depends on sqg_pkg.
module sqg_cmac (
  input  logic                             clk,
  input  sqg_pkg::sqg_en_t                 en,
  input  logic [sqg_pkg::GATE_W-1:0]       m0,
  input  logic [sqg_pkg::GATE_W-1:0]       m1,
  input  sqg_pkg::sqg_amp_t                x,
  output logic signed [sqg_pkg::AMP_W-1:0] re,
  output logic signed [sqg_pkg::AMP_W-1:0] im
);
  import sqg_pkg::*;

  localparam int PW = 2 * AMP_W;       // product
  localparam int SW = PW + 1;          // pair sum
  localparam int TW = PW + 2;          // total
  localparam int HW = TW - FRAC_BITS;  // integer part after floor

  logic signed [AMP_W-1:0] a0r, a0i, a1r, a1i;
  logic signed [PW-1:0]    p_nxt [8];
  logic signed [PW-1:0]    p_r   [8];
  logic signed [SW-1:0]    re0_r, re1_r, im0_r, im1_r;
  logic signed [TW-1:0]    re_sum, im_sum;
  logic signed [AMP_W-1:0] re_nxt, im_nxt, re_r, im_r;

  function automatic logic signed [AMP_W-1:0] floor_sat(input logic signed [TW-1:0] s);
    logic signed [HW-1:0] h;
    h = HW'(s >>> FRAC_BITS);
    if (h[HW-1:AMP_W-1] == '0 || h[HW-1:AMP_W-1] == '1) begin
      floor_sat = h[AMP_W-1:0];
    end else if (h[HW-1]) begin
      floor_sat = {1'b1, {(AMP_W - 1){1'b0}}};
    end else begin
      floor_sat = {1'b0, {(AMP_W - 1){1'b1}}};
    end
  endfunction

  assign a0r = m0[GATE_W-1:AMP_W];
  assign a0i = m0[AMP_W-1:0];
  assign a1r = m1[GATE_W-1:AMP_W];
  assign a1i = m1[AMP_W-1:0];

  always_comb begin
    p_nxt[0] = a0r * x.x0r;
    p_nxt[1] = a0i * x.x0i;
    p_nxt[2] = a1r * x.x1r;
    p_nxt[3] = a1i * x.x1i;
    p_nxt[4] = a0r * x.x0i;
    p_nxt[5] = a0i * x.x0r;
    p_nxt[6] = a1r * x.x1i;
    p_nxt[7] = a1i * x.x1r;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p_r <= p_nxt;
    end
    if (en.s3) begin
      re0_r <= {p_r[0][PW-1], p_r[0]} - {p_r[1][PW-1], p_r[1]};
      re1_r <= {p_r[2][PW-1], p_r[2]} - {p_r[3][PW-1], p_r[3]};
      im0_r <= {p_r[4][PW-1], p_r[4]} + {p_r[5][PW-1], p_r[5]};
      im1_r <= {p_r[6][PW-1], p_r[6]} + {p_r[7][PW-1], p_r[7]};
    end
    if (en.s4) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
    end
  end

  always_comb begin
    re_sum = {re0_r[SW-1], re0_r} + {re1_r[SW-1], re1_r};
    im_sum = {im0_r[SW-1], im0_r} + {im1_r[SW-1], im1_r};
    re_nxt = floor_sat(re_sum);
    im_nxt = floor_sat(im_sum);
  end

  assign re = re_r;
  assign im = im_r;

endmodule

// ----- rtl/single_qubit_gate_update_unit.sv -----
`timescale 1ns / 1ps
// Single-qubit gate update unit: applies a 2x2 complex Q2.30 gate to amplitude pairs.
// Pipeline: 4 register stages, S1 to S4 in the stage map below.
// Throughput: one pair per cycle while the output is not stalled (16 32x32 multipliers).
// Reset (rst_n, synchronous): empties the pipeline, sets target 0 and the identity gate.
// Depends on sqg_pkg, sqg_if, sqg_cfg_regs, sqg_addr_gen and sqg_cmac.
module single_qubit_gate_update_unit #(
  parameter int NUM_QUBITS = sqg_pkg::NUM_QUBITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sqg_in_if.sink                        in_ch,
  sqg_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [sqg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sqg_pkg::GATE_W-1:0]    cfg_wdata
);
  import sqg_pkg::*;

  // Stage map:
  //   S1: capture amplitudes, form both state addresses
  //   S2: sixteen products (eight per lane)
  //   S3: pairwise sums of products
  //   S4: final sum, floor to Q2.30, saturate; this is the output register
  // Each stage loads when it is empty or the stage after it advances, so
  // bubbles collapse and a new beat is taken while a result waits.

  sqg_cfg_t cfg;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1;
  sqg_en_t en;

  sqg_amp_t             amp1_r;
  logic [ADDR_W-1:0]    za_nxt, oa_nxt;
  logic [ADDR_W-1:0]    za1_r, oa1_r, za2_r, oa2_r, za3_r, oa3_r, za4_r, oa4_r;

  sqg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  sqg_addr_gen #(.NUM_QUBITS(NUM_QUBITS)) u_addr (
    .pair_index  (in_ch.pair_index),
    .target      (cfg.target),
    .zero_address(za_nxt),
    .one_address (oa_nxt)
  );

  // Stall chain from the output back to the input.
  always_comb begin
    en.s4 = !v4_r || out_ch.ready;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en1   = !v1_r || en.s2;
  end

  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1)   v1_r <= in_ch.valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  // Payload: no reset, qualified by the valid bits.
  always_ff @(posedge clk) begin
    if (en1) begin
      amp1_r.x0r <= in_ch.zero_amp_re;
      amp1_r.x0i <= in_ch.zero_amp_im;
      amp1_r.x1r <= in_ch.one_amp_re;
      amp1_r.x1i <= in_ch.one_amp_im;
      za1_r      <= za_nxt;
      oa1_r      <= oa_nxt;
    end
    if (en.s2) begin
      za2_r <= za1_r;
      oa2_r <= oa1_r;
    end
    if (en.s3) begin
      za3_r <= za2_r;
      oa3_r <= oa2_r;
    end
    if (en.s4) begin
      za4_r <= za3_r;
      oa4_r <= oa3_r;
    end
  end

  // Row 0 of the gate gives the target-bit-0 amplitude, row 1 the other.
  sqg_cmac u_row0 (
    .clk(clk),
    .en (en),
    .m0 (cfg.ul),
    .m1 (cfg.ur),
    .x  (amp1_r),
    .re (out_ch.new_zero_re),
    .im (out_ch.new_zero_im)
  );

  sqg_cmac u_row1 (
    .clk(clk),
    .en (en),
    .m0 (cfg.ll),
    .m1 (cfg.lr),
    .x  (amp1_r),
    .re (out_ch.new_one_re),
    .im (out_ch.new_one_im)
  );

  assign out_ch.valid        = v4_r;
  assign out_ch.zero_address = za4_r;
  assign out_ch.one_address  = oa4_r;

  // An accepted beat always lands in stage 1.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted beat did not reach stage 1");

  // A stalled stage 1 keeps its beat.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !en.s2 |=> v1_r)
    else $error("stage 1 beat lost under stall");

  // Input is held off only when every stage is full and the output is blocked.
  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v1_r && v2_r && v3_r && v4_r && !out_ch.ready)
    else $error("input stalled with room in the pipeline");

  // The two addresses of a pair differ in the target bit at most.
  a_addr_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $onehot0(out_ch.zero_address ^ out_ch.one_address))
    else $error("pair addresses differ in more than the target bit");

endmodule
